@@ hdl/cmwc_pkg.sv @@
// ----------------------------------------------------------------------------
// cmwc_pkg
// Shared constants, types and state codes for the lag-4096 complementary
// multiply-with-carry random generator.
// ----------------------------------------------------------------------------
`default_nettype none

package cmwc_pkg;

  localparam int unsigned LagDepth = 4096;
  localparam int unsigned DataW    = 32;
  localparam int unsigned MultW    = 15;
  localparam int unsigned ProdW    = DataW + MultW;
  localparam int unsigned CarryW   = 19;
  localparam int unsigned CountW   = 64;

  localparam logic [MultW-1:0]  CmwcMult   = MultW'(18782);
  localparam logic [DataW-1:0]  Golden     = 32'h9e37_79b9;
  localparam logic [DataW-1:0]  RBase      = 32'hffff_fffe;
  localparam logic [CarryW-1:0] CarryInit  = CarryW'(362436);

  localparam logic KindSeed = 1'b0;
  localparam logic KindDraw = 1'b1;

  typedef enum logic [2:0] {
    StClear,
    StIdle,
    StFill,
    StWarmRd,
    StMul,
    StWb
  } state_e;

  typedef struct packed {
    logic load;
    logic advance;
  } seedgen_ctrl_t;

endpackage

`default_nettype wire

@@ hdl/cmwc_seedgen.sv @@
// ----------------------------------------------------------------------------
// cmwc_seedgen
// Produces the table fill sequence from a seed word, one word per cycle while
// advance is high, keeping the last three words in a small window.
// ----------------------------------------------------------------------------
`default_nettype none

module cmwc_seedgen #(
  parameter int unsigned LAG_DEPTH = cmwc_pkg::LagDepth
) (
  input  wire logic                              clk_i,
  input  wire cmwc_pkg::seedgen_ctrl_t           ctrl_i,
  input  wire logic [cmwc_pkg::DataW-1:0]        seed_i,
  input  wire logic [$clog2(LAG_DEPTH)-1:0]      idx_i,
  output logic      [cmwc_pkg::DataW-1:0]        value_o
);

  localparam int unsigned IdxW = $clog2(LAG_DEPTH);

  logic [cmwc_pkg::DataW-1:0] w0_q, w1_q, w2_q;
  logic [cmwc_pkg::DataW-1:0] idx_ext;

  assign idx_ext = cmwc_pkg::DataW'(idx_i);

  always_comb begin
    priority if (idx_i == '0) begin
      value_o = w0_q;
    end else if (idx_i == IdxW'(1) || idx_i == IdxW'(2)) begin
      value_o = w0_q + cmwc_pkg::Golden;
    end else begin
      value_o = w2_q ^ w1_q ^ cmwc_pkg::Golden ^ idx_ext;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      w0_q <= seed_i;
    end else if (ctrl_i.advance) begin
      w2_q <= w1_q;
      w1_q <= w0_q;
      w0_q <= value_o;
    end
  end

endmodule

`default_nettype wire

@@ hdl/cmwc_lag4096_random_generator.sv @@
// ----------------------------------------------------------------------------
// cmwc_lag4096_random_generator
// Complementary multiply-with-carry generator, lag 4096, multiplier 18782.
// ----------------------------------------------------------------------------
// Usage:
//   An item is taken at a clock edge with start_i high and busy_o low.
//   kind_i = 1 draws one value; kind_i = 0 seeds from seed_value_i.
//   A draw shows random_value_o and draws_since_seed_o for one cycle with
//   result_valid_o high in StWb, after the table read and the product register.
//   busy_o is already low in that result cycle, so the next item can be taken
//   then; the read-multiply-write loop on the lag table holds one draw at a time.
//   A seed item gives no result. It fills all 4096 table words from the seed
//   generator, then runs 4096 silent draws, all with busy_o high.
//   After reset the table is cleared in one pass over all words with busy_o high;
//   index, carry and draw count come out of reset at once.
//   The receiver cannot stall; results must be taken when shown.
// ----------------------------------------------------------------------------
`default_nettype none

module cmwc_lag4096_random_generator #(
  parameter int unsigned LAG_DEPTH = cmwc_pkg::LagDepth
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  output logic                               busy_o,
  input  wire logic                          kind_i,
  input  wire logic [cmwc_pkg::DataW-1:0]    seed_value_i,
  output logic                               result_valid_o,
  output logic      [cmwc_pkg::DataW-1:0]    random_value_o,
  output logic      [cmwc_pkg::CountW-1:0]   draws_since_seed_o
);

  localparam int unsigned IdxW = $clog2(LAG_DEPTH);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(LAG_DEPTH - 1);

  localparam int unsigned DataW  = cmwc_pkg::DataW;
  localparam int unsigned ProdW  = cmwc_pkg::ProdW;
  localparam int unsigned CarryW = cmwc_pkg::CarryW;
  localparam int unsigned CountW = cmwc_pkg::CountW;

  cmwc_pkg::state_e state_q, state_d;

  logic [IdxW-1:0]   cnt_q, cnt_d;
  logic [IdxW-1:0]   index_q, index_d;
  logic [CarryW-1:0] carry_q, carry_d;
  logic [CountW-1:0] count_q, count_d;
  logic              warm_q, warm_d;
  logic [ProdW-1:0]  t_q, t_d;

  logic [DataW-1:0]  mem_q [LAG_DEPTH];
  logic [DataW-1:0]  rdata_q;
  logic              mem_we, mem_re;
  logic [IdxW-1:0]   mem_waddr, mem_raddr;
  logic [DataW-1:0]  mem_wdata;

  cmwc_pkg::seedgen_ctrl_t seed_ctrl;
  logic [DataW-1:0]        fill_value;

  logic [CarryW-1:0] c_hi, c_fin;
  logic [DataW:0]    sum_wide;
  logic              wrap;
  logic [DataW-1:0]  x_fin, rand_value;
  logic              accept;

  cmwc_seedgen #(
    .LAG_DEPTH (LAG_DEPTH)
  ) u_seedgen (
    .clk_i   (clk_i),
    .ctrl_i  (seed_ctrl),
    .seed_i  (seed_value_i),
    .idx_i   (cnt_q),
    .value_o (fill_value)
  );

  // finish of one draw step
  assign c_hi       = CarryW'(t_q[ProdW-1:DataW]);
  assign sum_wide   = {1'b0, t_q[DataW-1:0]} + (DataW+1)'(c_hi);
  assign wrap       = sum_wide[DataW];
  assign x_fin      = sum_wide[DataW-1:0] + DataW'(wrap);
  assign c_fin      = c_hi + CarryW'(wrap);
  assign rand_value = cmwc_pkg::RBase - x_fin;

  assign mem_raddr = index_q + IdxW'(1);
  assign accept    = start_i && !busy_o;

  assign random_value_o     = rand_value;
  assign draws_since_seed_o = count_q + CountW'(1);

  always_comb begin
    state_d        = state_q;
    cnt_d          = cnt_q;
    index_d        = index_q;
    carry_d        = carry_q;
    count_d        = count_q;
    warm_d         = warm_q;
    t_d            = ProdW'(cmwc_pkg::CmwcMult) * ProdW'(rdata_q) + ProdW'(carry_q);
    mem_we         = 1'b0;
    mem_re         = 1'b0;
    mem_waddr      = cnt_q;
    mem_wdata      = '0;
    seed_ctrl      = '0;
    busy_o         = 1'b1;
    result_valid_o = 1'b0;

    unique case (state_q)
      cmwc_pkg::StClear: begin
        mem_we = 1'b1;
        if (cnt_q == LastIdx) begin
          cnt_d   = '0;
          state_d = cmwc_pkg::StIdle;
        end else begin
          cnt_d = cnt_q + IdxW'(1);
        end
      end
      cmwc_pkg::StIdle: begin
        busy_o = 1'b0;
      end
      cmwc_pkg::StFill: begin
        mem_we            = 1'b1;
        mem_wdata         = fill_value;
        seed_ctrl.advance = 1'b1;
        if (cnt_q == LastIdx) begin
          cnt_d   = '0;
          state_d = cmwc_pkg::StWarmRd;
        end else begin
          cnt_d = cnt_q + IdxW'(1);
        end
      end
      cmwc_pkg::StWarmRd: begin
        mem_re  = 1'b1;
        index_d = mem_raddr;
        state_d = cmwc_pkg::StMul;
      end
      cmwc_pkg::StMul: begin
        state_d = cmwc_pkg::StWb;
      end
      cmwc_pkg::StWb: begin
        mem_we    = 1'b1;
        mem_waddr = index_q;
        mem_wdata = rand_value;
        carry_d   = c_fin;
        if (warm_q) begin
          if (cnt_q == LastIdx) begin
            cnt_d   = '0;
            warm_d  = 1'b0;
            state_d = cmwc_pkg::StIdle;
          end else begin
            cnt_d   = cnt_q + IdxW'(1);
            mem_re  = 1'b1;
            index_d = mem_raddr;
            state_d = cmwc_pkg::StMul;
          end
        end else begin
          busy_o         = 1'b0;
          result_valid_o = 1'b1;
          count_d        = count_q + CountW'(1);
          state_d        = cmwc_pkg::StIdle;
        end
      end
      default: begin
        state_d = cmwc_pkg::StIdle;
      end
    endcase

    // new item, taken in idle or in the result cycle of a draw
    if (accept) begin
      if (kind_i == cmwc_pkg::KindDraw) begin
        mem_re  = 1'b1;
        index_d = mem_raddr;
        state_d = cmwc_pkg::StMul;
      end else begin
        seed_ctrl.load = 1'b1;
        index_d        = LastIdx;
        carry_d        = cmwc_pkg::CarryInit;
        count_d        = '0;
        cnt_d          = '0;
        warm_d         = 1'b1;
        state_d        = cmwc_pkg::StFill;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= cmwc_pkg::StClear;
      cnt_q   <= '0;
      index_q <= '0;
      carry_q <= cmwc_pkg::CarryInit;
      count_q <= '0;
      warm_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      index_q <= index_d;
      carry_q <= carry_d;
      count_q <= count_d;
      warm_q  <= warm_d;
    end
  end

  always_ff @(posedge clk_i) begin
    t_q <= t_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem_q[mem_raddr];
    end
  end

endmodule

`default_nettype wire
